FILE: hw/rtl/skh_pkg.sv
package skh_pkg;

  // Default sizes
  localparam int unsigned TABLE_SLOTS_DEF  = 2048;
  localparam int unsigned POOL_ENTRIES_DEF = 512;
  localparam int unsigned KEY_BYTES_DEF    = 64;

  // Hash constants
  localparam logic [31:0] FNV_BASIS = 32'h811c_9dc5;
  localparam logic [31:0] FNV_PRIME = 32'h0100_0193;
  localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;

  // Action codes
  localparam logic [1:0] ACT_REGISTER = 2'd0;
  localparam logic [1:0] ACT_RESOLVE  = 2'd1;
  localparam logic [1:0] ACT_SET_EN   = 2'd2;
  localparam logic [1:0] ACT_CLEAR    = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_DISABLED  = 3'd2;
  localparam logic [2:0] ST_NO_SPACE  = 3'd3;
  localparam logic [2:0] ST_TOO_LONG  = 3'd4;

  // Commands from controller to datapath
  typedef struct packed {
    logic       take;
    logic       key_clr;
    logic       mod_start;
    logic       mod_step;
    logic       slot_rd;
    logic       slot_adv;
    logic       len_rd;
    logic       j_clr;
    logic       j_inc;
    logic       cmp_rd;
    logic       ent_rd;
    logic       copy_rd;
    logic       copy_wr;
    logic       ins;
    logic       upd;
    logic       sweep_start;
    logic       sweep_step;
    logic       cnt_clr;
    logic       res;
    logic       res_entry;
    logic [2:0] res_status;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [1:0] act;
    logic       ovf;
    logic       mod_done;
    logic       exhausted;
    logic       slot_valid;
    logic       idx_in_pool;
    logic       len_eq;
    logic       len_zero;
    logic       byte_eq;
    logic       cmp_last;
    logic       copy_done;
    logic       pool_full;
    logic       en_bit;
    logic       sweep_done;
  } sts_t;

  // Reflected CRC-32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/string_key_hash_table.sv
// Channel   Ports                                            Handshake
// command   action_i key_byte_i key_last_i entry_type_i      start & !busy
//           enable_value_i
// result    status_o entry_index_o stored_type_o             done_o, one cycle
//           slot_hash_o identity_hash_o
//
// A key byte that is not last is taken while busy stays low.
// On the last byte the block goes busy: it dispatches, reduces the FNV hash
// to a slot, then probes slots in turn, reading each slot and, for a live
// entry, its length and then each compared key byte; a hit reads the entry.
// An insert copies the key bytes into the pool and then writes the entry.
// Reset and clear each run a sweep over the slot table with busy high. Results
// cannot be stalled by the receiver.
module string_key_hash_table #(
  parameter int unsigned TABLE_SLOTS  = skh_pkg::TABLE_SLOTS_DEF,
  parameter int unsigned POOL_ENTRIES = skh_pkg::POOL_ENTRIES_DEF,
  parameter int unsigned KEY_BYTES    = skh_pkg::KEY_BYTES_DEF,
  localparam int unsigned IDX_W       = $clog2(POOL_ENTRIES)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       action_i,
  input  logic [7:0]       key_byte_i,
  input  logic             key_last_i,
  input  logic [3:0]       entry_type_i,
  input  logic             enable_value_i,
  output logic             done_o,
  output logic [2:0]       status_o,
  output logic [IDX_W-1:0] entry_index_o,
  output logic [3:0]       stored_type_o,
  output logic [31:0]      slot_hash_o,
  output logic [31:0]      identity_hash_o
);
  import skh_pkg::*;

  cmd_t cmd;
  sts_t sts;

  skh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .key_last_i (key_last_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .busy       (busy)
  );

  skh_datapath #(
    .TABLE_SLOTS  (TABLE_SLOTS),
    .POOL_ENTRIES (POOL_ENTRIES),
    .KEY_BYTES    (KEY_BYTES)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .action_i        (action_i),
    .key_byte_i      (key_byte_i),
    .entry_type_i    (entry_type_i),
    .enable_value_i  (enable_value_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .done_o          (done_o),
    .status_o        (status_o),
    .entry_index_o   (entry_index_o),
    .stored_type_o   (stored_type_o),
    .slot_hash_o     (slot_hash_o),
    .identity_hash_o (identity_hash_o)
  );

endmodule

FILE: hw/rtl/skh_ctrl.sv
module skh_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  logic          key_last_i,
  input  skh_pkg::sts_t sts_i,
  output skh_pkg::cmd_t cmd_o,
  output logic          busy
);
  import skh_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_MOD   = 4'd2;
  localparam logic [3:0] S_SRD   = 4'd3;
  localparam logic [3:0] S_SCHK  = 4'd4;
  localparam logic [3:0] S_LCHK  = 4'd5;
  localparam logic [3:0] S_CRD   = 4'd6;
  localparam logic [3:0] S_CCHK  = 4'd7;
  localparam logic [3:0] S_FRD   = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;
  localparam logic [3:0] S_CPRD  = 4'd10;
  localparam logic [3:0] S_CPWR  = 4'd11;
  localparam logic [3:0] S_SWEEP = 4'd12;

  logic [3:0] state_q, state_d;

  // Hold state; reset starts with the slot sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_SWEEP;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

  // Sequence the probe, compare, insert and sweep
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.take = 1'b1;
          if (key_last_i) state_d = S_DISP;
        end
      end
      S_DISP: begin
        if (sts_i.act == ACT_CLEAR) begin
          cmd_o.res         = 1'b1;
          cmd_o.res_status  = ST_OK;
          cmd_o.key_clr     = 1'b1;
          cmd_o.cnt_clr     = 1'b1;
          cmd_o.sweep_start = 1'b1;
          state_d           = S_SWEEP;
        end else if (sts_i.ovf) begin
          cmd_o.res        = 1'b1;
          cmd_o.res_status = ST_TOO_LONG;
          cmd_o.key_clr    = 1'b1;
          state_d          = S_IDLE;
        end else begin
          cmd_o.mod_start = 1'b1;
          state_d         = S_MOD;
        end
      end
      S_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (sts_i.mod_done) state_d = S_SRD;
      end
      S_SRD: begin
        if (sts_i.exhausted) begin
          cmd_o.res        = 1'b1;
          cmd_o.res_status = (sts_i.act == ACT_REGISTER) ? ST_NO_SPACE : ST_NOT_FOUND;
          cmd_o.key_clr    = 1'b1;
          state_d          = S_IDLE;
        end else begin
          cmd_o.slot_rd = 1'b1;
          state_d       = S_SCHK;
        end
      end
      S_SCHK: begin
        if (!sts_i.slot_valid) begin
          if (sts_i.act == ACT_REGISTER && !sts_i.pool_full) begin
            cmd_o.j_clr = 1'b1;
            state_d     = S_CPRD;
          end else begin
            cmd_o.res        = 1'b1;
            cmd_o.res_status = (sts_i.act == ACT_REGISTER) ? ST_NO_SPACE : ST_NOT_FOUND;
            cmd_o.key_clr    = 1'b1;
            state_d          = S_IDLE;
          end
        end else if (!sts_i.idx_in_pool) begin
          cmd_o.slot_adv = 1'b1;
          state_d        = S_SRD;
        end else begin
          cmd_o.len_rd = 1'b1;
          state_d      = S_LCHK;
        end
      end
      S_LCHK: begin
        priority if (!sts_i.len_eq) begin
          cmd_o.slot_adv = 1'b1;
          state_d        = S_SRD;
        end else if (sts_i.len_zero) begin
          state_d = S_FRD;
        end else begin
          cmd_o.j_clr = 1'b1;
          state_d     = S_CRD;
        end
      end
      S_CRD: begin
        cmd_o.cmp_rd = 1'b1;
        state_d      = S_CCHK;
      end
      S_CCHK: begin
        priority if (!sts_i.byte_eq) begin
          cmd_o.slot_adv = 1'b1;
          state_d        = S_SRD;
        end else if (sts_i.cmp_last) begin
          state_d = S_FRD;
        end else begin
          cmd_o.j_inc = 1'b1;
          state_d     = S_CRD;
        end
      end
      S_FRD: begin
        cmd_o.ent_rd = 1'b1;
        state_d      = S_FIN;
      end
      S_FIN: begin
        cmd_o.upd        = 1'b1;
        cmd_o.res        = 1'b1;
        cmd_o.res_entry  = 1'b1;
        cmd_o.res_status = (sts_i.act == ACT_RESOLVE && !sts_i.en_bit) ? ST_DISABLED : ST_OK;
        cmd_o.key_clr    = 1'b1;
        state_d          = S_IDLE;
      end
      S_CPRD: begin
        if (sts_i.copy_done) begin
          cmd_o.ins        = 1'b1;
          cmd_o.res        = 1'b1;
          cmd_o.res_entry  = 1'b1;
          cmd_o.res_status = ST_OK;
          cmd_o.key_clr    = 1'b1;
          state_d          = S_IDLE;
        end else begin
          cmd_o.copy_rd = 1'b1;
          state_d       = S_CPWR;
        end
      end
      S_CPWR: begin
        cmd_o.copy_wr = 1'b1;
        cmd_o.j_inc   = 1'b1;
        state_d       = S_CPRD;
      end
      S_SWEEP: begin
        cmd_o.sweep_step = 1'b1;
        if (sts_i.sweep_done) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

FILE: hw/rtl/skh_datapath.sv
module skh_datapath #(
  parameter int unsigned TABLE_SLOTS  = skh_pkg::TABLE_SLOTS_DEF,
  parameter int unsigned POOL_ENTRIES = skh_pkg::POOL_ENTRIES_DEF,
  parameter int unsigned KEY_BYTES    = skh_pkg::KEY_BYTES_DEF,
  localparam int unsigned IDX_W       = $clog2(POOL_ENTRIES)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [1:0]       action_i,
  input  logic [7:0]       key_byte_i,
  input  logic [3:0]       entry_type_i,
  input  logic             enable_value_i,
  input  skh_pkg::cmd_t    cmd_i,
  output skh_pkg::sts_t    sts_o,
  output logic             done_o,
  output logic [2:0]       status_o,
  output logic [IDX_W-1:0] entry_index_o,
  output logic [3:0]       stored_type_o,
  output logic [31:0]      slot_hash_o,
  output logic [31:0]      identity_hash_o
);
  import skh_pkg::*;

  localparam int unsigned SLOT_W = $clog2(TABLE_SLOTS);
  localparam int unsigned N_W    = $clog2(TABLE_SLOTS + 1);
  localparam int unsigned CNT_W  = $clog2(POOL_ENTRIES + 1);
  localparam int unsigned KB_AW  = $clog2(KEY_BYTES);
  localparam int unsigned KL_W   = $clog2(KEY_BYTES + 1);
  localparam int unsigned KEYS_D = POOL_ENTRIES << KB_AW;
  localparam logic [31:0] RECIP  = 32'((64'd1 << 32) / 64'(TABLE_SLOTS));

  // Key assembly state
  logic [31:0]     fnv_q, crc_q;
  logic [KL_W-1:0] key_len_q;
  logic            ovf_q;
  logic [1:0]      act_q;
  logic [3:0]      type_in_q;
  logic            en_in_q;

  // Probe state
  logic [SLOT_W-1:0] slot_q, sw_q;
  logic [N_W-1:0]    n_q;
  logic [1:0]        mc_q;
  logic [31:0]       quot_q, diff_q;
  logic [CNT_W-1:0]  count_q;
  logic [IDX_W-1:0]  idx_q;
  logic [KL_W-1:0]   j_q;

  // Memories and their read registers
  logic [IDX_W:0]    slot_mem [TABLE_SLOTS];
  logic [KL_W-1:0]   len_mem  [POOL_ENTRIES];
  logic [3:0]        type_mem [POOL_ENTRIES];
  logic              en_mem   [POOL_ENTRIES];
  logic [7:0]        keys_mem [KEYS_D];
  logic [7:0]        kbuf_mem [KEY_BYTES];
  logic [IDX_W:0]    slot_rd_q;
  logic [KL_W-1:0]   len_rd_q;
  logic [3:0]        type_rd_q;
  logic              en_rd_q;
  logic [7:0]        key_rd_q, kbuf_rd_q;

  logic              absorb, key_full;
  logic [63:0]       prod;
  logic [SLOT_W-1:0] rem_next;
  logic              slot_we;
  logic [SLOT_W-1:0] slot_wa;
  logic [IDX_W:0]    slot_wd;
  logic [IDX_W-1:0]  new_idx;
  logic              type_we, en_we, en_wd;
  logic [IDX_W-1:0]  ent_wa;

  assign absorb   = cmd_i.take && (key_byte_i != 8'd0);
  assign key_full = (key_len_q == KL_W'(KEY_BYTES));
  assign new_idx  = count_q[IDX_W-1:0];

  // Slot from the hash: reciprocal multiply, back-multiply, one correcting subtract
  always_comb begin
    prod     = 64'(fnv_q) * 64'(RECIP);
    rem_next = (diff_q >= 32'(TABLE_SLOTS)) ?
               SLOT_W'(diff_q - 32'(TABLE_SLOTS)) : SLOT_W'(diff_q);
  end

  // Hash, key length and captured item fields
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fnv_q     <= FNV_BASIS;
      crc_q     <= CRC_INIT;
      key_len_q <= '0;
      ovf_q     <= 1'b0;
      act_q     <= ACT_REGISTER;
      type_in_q <= '0;
      en_in_q   <= 1'b0;
    end else begin
      if (cmd_i.key_clr) begin
        fnv_q     <= FNV_BASIS;
        crc_q     <= CRC_INIT;
        key_len_q <= '0;
        ovf_q     <= 1'b0;
      end else if (absorb) begin
        fnv_q <= 32'((fnv_q ^ {24'd0, key_byte_i}) * FNV_PRIME);
        crc_q <= crc_byte(crc_q, key_byte_i);
        if (key_full) ovf_q <= 1'b1;
        else key_len_q <= key_len_q + 1'b1;
      end
      if (cmd_i.take) begin
        act_q     <= action_i;
        type_in_q <= entry_type_i;
        en_in_q   <= enable_value_i;
      end
    end
  end

  // Probe counters, pool fill and sweep pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= '0;
      n_q     <= '0;
      mc_q    <= '0;
      quot_q  <= '0;
      diff_q  <= '0;
      count_q <= '0;
      idx_q   <= '0;
      j_q     <= '0;
      sw_q    <= '0;
    end else begin
      if (cmd_i.mod_start) begin
        slot_q <= '0;
        mc_q   <= '0;
        n_q    <= '0;
      end else if (cmd_i.mod_step) begin
        mc_q <= mc_q + 1'b1;
        if (mc_q == 2'd0) quot_q <= prod[63:32];
        if (mc_q == 2'd1) diff_q <= fnv_q - 32'(quot_q * TABLE_SLOTS);
        if (mc_q == 2'd2) slot_q <= rem_next;
      end else if (cmd_i.slot_adv) begin
        slot_q <= (slot_q == SLOT_W'(TABLE_SLOTS - 1)) ? '0 : slot_q + 1'b1;
        n_q    <= n_q + 1'b1;
      end
      if (cmd_i.len_rd) idx_q <= slot_rd_q[IDX_W-1:0];
      else if (cmd_i.ins) idx_q <= new_idx;
      if (cmd_i.j_clr) j_q <= '0;
      else if (cmd_i.j_inc) j_q <= j_q + 1'b1;
      if (cmd_i.cnt_clr) count_q <= '0;
      else if (cmd_i.ins) count_q <= count_q + 1'b1;
      if (cmd_i.sweep_start) sw_q <= '0;
      else if (cmd_i.sweep_step) sw_q <= sw_q + 1'b1;
    end
  end

  // Slot table port: sweep clears, insert claims
  always_comb begin
    slot_we = cmd_i.sweep_step || cmd_i.ins;
    slot_wa = cmd_i.sweep_step ? sw_q : slot_q;
    slot_wd = cmd_i.ins ? {1'b1, new_idx} : '0;
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) slot_mem[slot_wa] <= slot_wd;
    if (cmd_i.slot_rd) slot_rd_q <= slot_mem[slot_q];
  end

  // Entry length store
  always_ff @(posedge clk_i) begin
    if (cmd_i.ins) len_mem[new_idx] <= key_len_q;
    if (cmd_i.len_rd) len_rd_q <= len_mem[slot_rd_q[IDX_W-1:0]];
  end

  // Type and enable stores
  always_comb begin
    ent_wa  = cmd_i.ins ? new_idx : idx_q;
    type_we = cmd_i.ins || (cmd_i.upd && act_q == ACT_REGISTER);
    en_we   = cmd_i.ins ||
              (cmd_i.upd && (act_q == ACT_REGISTER || act_q == ACT_SET_EN));
    en_wd   = (cmd_i.upd && act_q == ACT_SET_EN) ? en_in_q : 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (type_we) type_mem[ent_wa] <= type_in_q;
    if (en_we) en_mem[ent_wa] <= en_wd;
    if (cmd_i.ent_rd) begin
      type_rd_q <= type_mem[idx_q];
      en_rd_q   <= en_mem[idx_q];
    end
  end

  // Key buffer: fill on absorb, read for compare and copy
  always_ff @(posedge clk_i) begin
    if (absorb && !key_full) kbuf_mem[key_len_q[KB_AW-1:0]] <= key_byte_i;
    if (cmd_i.cmp_rd || cmd_i.copy_rd) kbuf_rd_q <= kbuf_mem[j_q[KB_AW-1:0]];
  end

  // Entry key bytes
  always_ff @(posedge clk_i) begin
    if (cmd_i.copy_wr) keys_mem[{new_idx, j_q[KB_AW-1:0]}] <= kbuf_rd_q;
    if (cmd_i.cmp_rd) key_rd_q <= keys_mem[{idx_q, j_q[KB_AW-1:0]}];
  end

  // Result register, one-cycle strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= cmd_i.res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res) begin
      status_o        <= cmd_i.res_status;
      slot_hash_o     <= fnv_q;
      identity_hash_o <= ~crc_q;
      if (cmd_i.res_entry) begin
        entry_index_o <= cmd_i.ins ? new_idx : idx_q;
        stored_type_o <= (act_q == ACT_REGISTER) ? type_in_q : type_rd_q;
      end else begin
        entry_index_o <= '0;
        stored_type_o <= '0;
      end
    end
  end

  // Status to controller
  always_comb begin
    sts_o.act         = act_q;
    sts_o.ovf         = ovf_q;
    sts_o.mod_done    = (mc_q == 2'd2);
    sts_o.exhausted   = (n_q == N_W'(TABLE_SLOTS));
    sts_o.slot_valid  = slot_rd_q[IDX_W];
    sts_o.idx_in_pool = (CNT_W'(slot_rd_q[IDX_W-1:0]) < count_q);
    sts_o.len_eq      = (len_rd_q == key_len_q);
    sts_o.len_zero    = (key_len_q == '0);
    sts_o.byte_eq     = (key_rd_q == kbuf_rd_q);
    sts_o.cmp_last    = ((j_q + 1'b1) == key_len_q);
    sts_o.copy_done   = (j_q == key_len_q);
    sts_o.pool_full   = (count_q == CNT_W'(POOL_ENTRIES));
    sts_o.en_bit      = en_rd_q;
    sts_o.sweep_done  = (sw_q == SLOT_W'(TABLE_SLOTS - 1));
  end

endmodule

FILE: tb/tb.sv
module tb;
  import skh_pkg::*;

  localparam int unsigned SLOTS     = TABLE_SLOTS_DEF;
  localparam int unsigned POOL      = POOL_ENTRIES_DEF;
  localparam int unsigned KEYMAX    = KEY_BYTES_DEF;
  localparam int unsigned CYCLE_CAP = 1000000;

  typedef struct {
    logic [2:0]  status;
    logic [8:0]  index;
    logic [3:0]  stype;
    logic [31:0] fnv;
    logic [31:0] crc;
  } lookup_res_t;

  typedef struct {
    logic [1:0] act;
    logic [7:0] kbyte;
    logic       last;
    logic [3:0] etype;
    logic       en;
    bit         fixed;
    logic [2:0] status;
    logic [8:0] index;
    logic [3:0] stype;
  } cmd_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [1:0]  action_i;
  logic [7:0]  key_byte_i;
  logic        key_last_i;
  logic [3:0]  entry_type_i;
  logic        enable_value_i;
  logic        done_o;
  logic [2:0]  status_o;
  logic [8:0]  entry_index_o;
  logic [3:0]  stored_type_o;
  logic [31:0] slot_hash_o;
  logic [31:0] identity_hash_o;

  // Shadow copy of the table state
  bit          mdl_slot_valid [SLOTS];
  int unsigned mdl_slot_idx [SLOTS];
  int unsigned mdl_count;
  logic [7:0]  mdl_keys [POOL][KEYMAX];
  int unsigned mdl_klen [POOL];
  logic [3:0]  mdl_type [POOL];
  bit          mdl_en [POOL];
  logic [7:0]  cur_key [KEYMAX];
  int unsigned cur_len;
  logic [31:0] cur_fnv;
  logic [31:0] cur_crc;
  bit          cur_ovf;

  lookup_res_t pending_results [$];
  int unsigned errors;
  int unsigned cycles;
  int unsigned n_items;
  int unsigned n_results;
  int unsigned n_status [8];

  string_key_hash_table i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .action_i       (action_i),
    .key_byte_i     (key_byte_i),
    .key_last_i     (key_last_i),
    .entry_type_i   (entry_type_i),
    .enable_value_i (enable_value_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .entry_index_o  (entry_index_o),
    .stored_type_o  (stored_type_o),
    .slot_hash_o    (slot_hash_o),
    .identity_hash_o(identity_hash_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Restart the key accumulator
  function automatic void key_reset();
    cur_len = 0;
    cur_fnv = FNV_BASIS;
    cur_crc = CRC_INIT;
    cur_ovf = 1'b0;
  endfunction

  // Fold one byte into both hashes and the key buffer
  function automatic void key_fold(input logic [7:0] b);
    logic [31:0] c;
    cur_fnv = (cur_fnv ^ {24'd0, b}) * FNV_PRIME;
    c = cur_crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    cur_crc = c;
    if (cur_len < KEYMAX) begin
      cur_key[cur_len] = b;
      cur_len++;
    end else begin
      cur_ovf = 1'b1;
    end
  endfunction

  function automatic bit key_equal(input int unsigned idx);
    if (mdl_klen[idx] != cur_len) return 1'b0;
    for (int i = 0; i < cur_len; i++) if (mdl_keys[idx][i] != cur_key[i]) return 1'b0;
    return 1'b1;
  endfunction

  // Walk slots linearly: 1 found, 0 empty slot reached, -1 table exhausted
  function automatic int probe_slots(input logic [31:0] h, output int unsigned slot,
                                     output int unsigned idx);
    int unsigned s;
    s = h % SLOTS;
    slot = 0;
    idx = 0;
    for (int n = 0; n < SLOTS; n++) begin
      if (!mdl_slot_valid[s]) begin
        slot = s;
        return 0;
      end
      if (mdl_slot_idx[s] < mdl_count && key_equal(mdl_slot_idx[s])) begin
        idx = mdl_slot_idx[s];
        return 1;
      end
      s = (s + 1 == SLOTS) ? 0 : s + 1;
    end
    return -1;
  endfunction

  // Apply one transaction to the shadow table; return 1 when it yields a result
  function automatic bit predict_lookup(input cmd_row_t c, output lookup_res_t r);
    int unsigned slot, idx;
    int hit;
    if (c.kbyte != 8'd0) key_fold(c.kbyte);
    if (!c.last) return 1'b0;
    r.status = ST_OK;
    r.index  = '0;
    r.stype  = '0;
    r.fnv    = cur_fnv;
    r.crc    = ~cur_crc;
    if (c.act == ACT_CLEAR) begin
      for (int s = 0; s < SLOTS; s++) mdl_slot_valid[s] = 1'b0;
      mdl_count = 0;
    end else if (cur_ovf) begin
      r.status = ST_TOO_LONG;
    end else begin
      hit = probe_slots(cur_fnv, slot, idx);
      if (c.act == ACT_REGISTER) begin
        if (hit == 1) begin
          mdl_type[idx] = c.etype;
          mdl_en[idx] = 1'b1;
          r.index = 9'(idx);
          r.stype = c.etype;
        end else if (hit == 0 && mdl_count < POOL) begin
          idx = mdl_count++;
          for (int i = 0; i < cur_len; i++) mdl_keys[idx][i] = cur_key[i];
          mdl_klen[idx] = cur_len;
          mdl_type[idx] = c.etype;
          mdl_en[idx] = 1'b1;
          mdl_slot_valid[slot] = 1'b1;
          mdl_slot_idx[slot] = idx;
          r.index = 9'(idx);
          r.stype = c.etype;
        end else begin
          r.status = ST_NO_SPACE;
        end
      end else if (hit != 1) begin
        r.status = ST_NOT_FOUND;
      end else if (c.act == ACT_RESOLVE) begin
        r.index = 9'(idx);
        r.stype = mdl_type[idx];
        if (!mdl_en[idx]) r.status = ST_DISABLED;
      end else begin
        mdl_en[idx] = c.en;
        r.index = 9'(idx);
        r.stype = mdl_type[idx];
      end
    end
    key_reset();
    return 1'b1;
  endfunction

  // Drive one transaction, hold until busy is low after an edge, then predict
  task automatic issue_cmd(input cmd_row_t c);
    lookup_res_t r;
    int unsigned gap;
    start          <= 1'b1;
    action_i       <= c.act;
    key_byte_i     <= c.kbyte;
    key_last_i     <= c.last;
    entry_type_i   <= c.etype;
    enable_value_i <= c.en;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    n_items++;
    if (predict_lookup(c, r)) begin
      if (c.fixed) begin
        r.status = c.status;
        r.index  = c.index;
        r.stype  = c.stype;
      end
      pending_results.push_back(r);
    end
    // Idle the command side now and then, mostly briefly
    if ($urandom_range(0, 99) < 30) begin
      gap = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic cmd_row_t mk(input logic [1:0] a, input logic [7:0] b, input logic l,
                                  input logic [3:0] t = 4'd0, input logic e = 1'b0);
    cmd_row_t c;
    c.act = a;
    c.kbyte = b;
    c.last = l;
    c.etype = t;
    c.en = e;
    c.fixed = 1'b0;
    c.status = '0;
    c.index = '0;
    c.stype = '0;
    return c;
  endfunction

  function automatic cmd_row_t mkx(input cmd_row_t c, input logic [2:0] s,
                                   input logic [8:0] i, input logic [3:0] t);
    c.fixed = 1'b1;
    c.status = s;
    c.index = i;
    c.stype = t;
    return c;
  endfunction

  // Send a whole key, ending either on a zero byte or on its final byte
  task automatic issue_key(input logic [1:0] a, input logic [7:0] k [$], input logic [3:0] t,
                           input logic e);
    bit zero_end;
    zero_end = (k.size() == 0) || $urandom_range(0, 1);
    for (int i = 0; i < k.size(); i++) begin
      if ($urandom_range(0, 99) < 8) issue_cmd(mk(2'($urandom_range(0, 3)), 8'd0, 1'b0));
      issue_cmd(mk(zero_end ? 2'($urandom_range(0, 3)) : a, k[i],
                   !zero_end && i == k.size() - 1, 4'($urandom_range(0, 15)),
                   1'($urandom_range(0, 1))));
    end
    if (zero_end) issue_cmd(mk(a, 8'd0, 1'b1, t, e));
  endtask

  // Compare each result strobe against the oldest expectation
  always @(posedge clk_i) begin
    lookup_res_t x;
    if (rst_ni) begin
      cycles <= cycles + 1;
      if (done_o) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: status %0d index %0d", status_o, entry_index_o);
          errors++;
        end else begin
          x = pending_results.pop_front();
          n_results++;
          n_status[x.status]++;
          if (status_o !== x.status) begin
            $error("status: expected %0d, actual %0d", x.status, status_o);
            errors++;
          end
          if (entry_index_o !== x.index) begin
            $error("entry_index: expected %0d, actual %0d", x.index, entry_index_o);
            errors++;
          end
          if (stored_type_o !== x.stype) begin
            $error("stored_type: expected %0d, actual %0d", x.stype, stored_type_o);
            errors++;
          end
          if (slot_hash_o !== x.fnv) begin
            $error("slot_hash: expected %h, actual %h", x.fnv, slot_hash_o);
            errors++;
          end
          if (identity_hash_o !== x.crc) begin
            $error("identity_hash: expected %h, actual %h", x.crc, identity_hash_o);
            errors++;
          end
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    cmd_row_t    dir_rows [$];
    logic [7:0]  k [$];
    logic [7:0]  recent [$][$];
    logic [7:0]  alpha [4];
    int unsigned n, len;
    logic [1:0]  a;

    errors = 0;
    cycles = 0;
    n_items = 0;
    n_results = 0;
    for (int i = 0; i < 8; i++) n_status[i] = 0;
    for (int s = 0; s < SLOTS; s++) mdl_slot_valid[s] = 1'b0;
    mdl_count = 0;
    key_reset();

    start = 1'b0;
    action_i = '0;
    key_byte_i = '0;
    key_last_i = 1'b0;
    entry_type_i = '0;
    enable_value_i = 1'b0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty key lifecycle, extremes, zero bytes, clear
    dir_rows.push_back(mkx(mk(ACT_RESOLVE, 8'd0, 1'b1), ST_NOT_FOUND, 9'd0, 4'd0));
    dir_rows.push_back(mkx(mk(ACT_SET_EN, 8'd0, 1'b1, 4'd0, 1'b1), ST_NOT_FOUND, 9'd0, 4'd0));
    dir_rows.push_back(mkx(mk(ACT_REGISTER, 8'd0, 1'b1, 4'd15), ST_OK, 9'd0, 4'd15));
    dir_rows.push_back(mkx(mk(ACT_RESOLVE, 8'd0, 1'b1), ST_OK, 9'd0, 4'd15));
    dir_rows.push_back(mkx(mk(ACT_SET_EN, 8'd0, 1'b1, 4'd0, 1'b0), ST_OK, 9'd0, 4'd15));
    dir_rows.push_back(mkx(mk(ACT_RESOLVE, 8'd0, 1'b1), ST_DISABLED, 9'd0, 4'd15));
    dir_rows.push_back(mk(ACT_REGISTER, 8'hFF, 1'b0));
    dir_rows.push_back(mk(ACT_CLEAR, 8'd0, 1'b0));
    dir_rows.push_back(mkx(mk(ACT_REGISTER, 8'h01, 1'b1, 4'd0), ST_OK, 9'd1, 4'd0));
    dir_rows.push_back(mk(ACT_RESOLVE, 8'hFF, 1'b0));
    dir_rows.push_back(mk(ACT_RESOLVE, 8'h01, 1'b1));
    dir_rows.push_back(mk(ACT_SET_EN, 8'hFF, 1'b0));
    dir_rows.push_back(mk(ACT_SET_EN, 8'h01, 1'b1, 4'd0, 1'b1));
    dir_rows.push_back(mkx(mk(ACT_REGISTER, 8'd0, 1'b1, 4'd5), ST_OK, 9'd0, 4'd5));
    dir_rows.push_back(mk(ACT_RESOLVE, 8'h80, 1'b1));
    dir_rows.push_back(mkx(mk(ACT_CLEAR, 8'h55, 1'b1), ST_OK, 9'd0, 4'd0));
    dir_rows.push_back(mkx(mk(ACT_RESOLVE, 8'd0, 1'b1), ST_NOT_FOUND, 9'd0, 4'd0));
    foreach (dir_rows[i]) issue_cmd(dir_rows[i]);

    // Directed: key at the buffer limit, one byte over, and clear of an over-long key
    for (int v = 0; v < 3; v++) begin
      len = (v == 0) ? KEYMAX : KEYMAX + 1;
      for (int i = 0; i < len - 1; i++) issue_cmd(mk(ACT_REGISTER, 8'(i + 1), 1'b0));
      a = (v == 2) ? ACT_CLEAR : ACT_REGISTER;
      if (v == 1) issue_cmd(mkx(mk(a, 8'hAA, 1'b1, 4'd3), ST_TOO_LONG, 9'd0, 4'd0));
      else issue_cmd(mk(a, 8'hAA, 1'b1, 4'd3));
    end

    // Fill the pool with distinct two-byte keys, then run past its end
    for (int i = 0; i < POOL + 8; i++) begin
      issue_cmd(mk(ACT_REGISTER, 8'(1 + i / 255), 1'b0));
      if (i >= POOL) issue_cmd(mkx(mk(ACT_REGISTER, 8'(1 + i % 255), 1'b1, 4'(i)),
                                   ST_NO_SPACE, 9'd0, 4'd0));
      else issue_cmd(mk(ACT_REGISTER, 8'(1 + i % 255), 1'b1, 4'(i)));
    end
    for (int i = 0; i < 12; i++) begin
      n = $urandom_range(0, POOL - 1);
      issue_cmd(mk(ACT_RESOLVE, 8'(1 + n / 255), 1'b0));
      issue_cmd(mk(i[0] ? ACT_RESOLVE : ACT_SET_EN, 8'(1 + n % 255), 1'b1, 4'd0,
                   1'($urandom_range(0, 1))));
    end
    issue_cmd(mk(ACT_CLEAR, 8'd0, 1'b1));

    // Random keys over a small alphabet so that hits and overwrites are common
    alpha[0] = 8'h01;
    alpha[1] = 8'h61;
    alpha[2] = 8'h80;
    alpha[3] = 8'hFE;
    while (n_items < 1350) begin
      k.delete();
      n = $urandom_range(0, 99);
      if (n < 4) len = $urandom_range(KEYMAX - 1, KEYMAX + 3);
      else len = $urandom_range(0, 4);
      if (recent.size() > 0 && $urandom_range(0, 99) < 45 && n >= 4) begin
        k = recent[$urandom_range(0, recent.size() - 1)];
      end else begin
        for (int i = 0; i < len; i++)
          k.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) :
                      alpha[$urandom_range(0, 3)]);
        if (k.size() <= 8) begin
          recent.push_back(k);
          if (recent.size() > 24) void'(recent.pop_front());
        end
      end
      n = $urandom_range(0, 99);
      a = (n < 40) ? ACT_REGISTER : (n < 70) ? ACT_RESOLVE : (n < 97) ? ACT_SET_EN : ACT_CLEAR;
      issue_key(a, k, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
    end
    start <= 1'b0;

    // Drain and let the block settle
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    $display("covered %0d transactions, %0d results: ok %0d, not found %0d, disabled %0d,",
             n_items, n_results, n_status[ST_OK], n_status[ST_NOT_FOUND], n_status[ST_DISABLED]);
    $display("no space %0d, key too long %0d, with a full pool and several clears",
             n_status[ST_NO_SPACE], n_status[ST_TOO_LONG]);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
